FILE: rtl/hse_pkg.sv
// Package for the heap sort engine: data width and default capacity.
// No dependencies; used by hse_ram and heap_sort_engine.
`default_nettype none

package hse_pkg;

   localparam int DATA_W    = 32;
   localparam int DEPTH_DEF = 64;

endpackage

`default_nettype wire

FILE: rtl/hse_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on hse_pkg for default parameter values.
`default_nettype none

module hse_ram #(
   parameter int WIDTH = hse_pkg::DATA_W,
   parameter int DEPTH = hse_pkg::DEPTH_DEF,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/heap_sort_engine.sv
// Heap sort engine top level: load sequencer, sift-down unit and result register.
// Depends on hse_pkg and hse_ram.
`default_nettype none

// Values arrive one item per cycle while req_stall is low and are written in
// arrival order into a DEPTH-entry store; an item with end_of_set high closes
// the set. Items beyond DEPTH are dropped and every result of that set then
// has rsp_overflowed set. The block then builds a max-heap in place and
// extracts the root repeatedly, all with one sift-down unit and a single
// read port whose data is registered. Each sift-down level reads the right
// child, reads the left child, then compares and writes back. Building the
// heap fetches each parent, last first, and sifts it down; each extraction
// reads the root and the last element, moves the old root to the end and
// sifts the old last element down from the root. Results then leave in
// ascending order, each held until taken before the next is fetched, with
// rsp_final_result on the largest. req_stall is high from the closing item
// until the last result has been taken.
module heap_sort_engine #(
   parameter int DEPTH = hse_pkg::DEPTH_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic signed [hse_pkg::DATA_W-1:0] req_value,
   input  wire logic                              req_end_of_set,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic signed      [hse_pkg::DATA_W-1:0] rsp_sorted_value,
   output logic                                   rsp_final_result,
   output logic                                   rsp_overflowed
);

   localparam int DW    = hse_pkg::DATA_W;
   localparam int AW    = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CW    = AW + 2;   // child index, up to 2*DEPTH

   typedef enum logic [3:0] {
      S_LOAD,
      S_BNEXT,
      S_FETCH,
      S_LATCH,
      S_RDR,
      S_RDL,
      S_DEC,
      S_XNEXT,
      S_XRD0,
      S_XRDE,
      S_XSWP,
      S_ERD,
      S_ELD,
      S_EWAIT
   } state_type;

   state_type              state_ff, state_in;
   logic [CNT_W-1:0]       count_ff, count_in;   // elements in current set
   logic                   ovf_ff, ovf_in;
   logic [CNT_W-1:0]       loop_ff, loop_in;     // build / extract counter
   logic [CNT_W-1:0]       size_ff, size_in;     // current heap size
   logic [AW-1:0]          node_ff, node_in;     // hole position
   logic                   extract_ff, extract_in;
   logic [AW-1:0]          k_ff, k_in;           // emit index
   logic signed [DW-1:0]   sift_ff, sift_in;     // value being sifted
   logic signed [DW-1:0]   big_ff, big_in;       // largest seen this level
   logic                   pick_r_ff, pick_r_in;
   logic signed [DW-1:0]   hold_ff, hold_in;     // old root during swap
   logic                   rsp_valid_ff, rsp_valid_in;
   logic signed [DW-1:0]   rsp_value_ff, rsp_value_in;
   logic                   rsp_final_ff, rsp_final_in;
   logic                   rsp_ovf_ff, rsp_ovf_in;

   logic                   wr_en;
   logic [AW-1:0]          wr_addr;
   logic [DW-1:0]          wr_data;
   logic [AW-1:0]          rd_addr;
   logic [DW-1:0]          rd_raw;
   logic signed [DW-1:0]   rd_data;

   logic [CW-1:0]          left_idx;
   logic [CW-1:0]          right_idx;
   logic [CW-1:0]          size_ext;
   logic                   left_ok;
   logic                   right_ok;
   logic                   left_wins;
   logic                   right_wins;

   hse_ram #(
      .WIDTH (DW),
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   assign rd_data    = $signed(rd_raw);
   assign left_idx   = {1'b0, node_ff, 1'b1};
   assign right_idx  = left_idx + CW'(1);
   assign size_ext   = CW'(size_ff);
   assign left_ok    = left_idx < size_ext;
   assign right_ok   = right_idx < size_ext;
   // strict greater-than only: a child equal to the sifted value never moves; between equal children the right one wins
   assign right_wins = right_ok && (rd_data > sift_ff);
   assign left_wins  = left_ok && (rd_data > big_ff);

   assign req_stall        = (state_ff != S_LOAD);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sorted_value = rsp_value_ff;
   assign rsp_final_result = rsp_final_ff;
   assign rsp_overflowed   = rsp_ovf_ff;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      loop_in      = loop_ff;
      size_in      = size_ff;
      node_in      = node_ff;
      extract_in   = extract_ff;
      k_in         = k_ff;
      sift_in      = sift_ff;
      big_in       = big_ff;
      pick_r_in    = pick_r_ff;
      hold_in      = hold_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_final_in = rsp_final_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      wr_en        = 1'b0;
      wr_addr      = node_ff;
      wr_data      = sift_ff;
      rd_addr      = node_ff;

      case (state_ff)
         S_LOAD: begin
            // store the item, or drop it once the store is full
            if (req_valid) begin
               if (count_ff < CNT_W'(DEPTH)) begin
                  wr_en    = 1'b1;
                  wr_addr  = AW'(count_ff);
                  wr_data  = req_value;
                  count_in = count_ff + CNT_W'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_end_of_set) begin
                  // count_in is the final set size here
                  loop_in    = count_in >> 1;
                  extract_in = 1'b0;
                  state_in   = S_BNEXT;
               end
            end
         end

         S_BNEXT: begin
            // heapify: sift each parent, last parent first
            if (loop_ff == '0) begin
               loop_in    = count_ff;
               extract_in = 1'b1;
               state_in   = S_XNEXT;
            end else begin
               node_in  = AW'(loop_ff - CNT_W'(1));
               loop_in  = loop_ff - CNT_W'(1);
               size_in  = count_ff;
               state_in = S_FETCH;
            end
         end

         S_FETCH: begin
            rd_addr  = node_ff;
            state_in = S_LATCH;
         end

         S_LATCH: begin
            sift_in  = rd_data;
            rd_addr  = right_idx[AW-1:0];
            state_in = S_RDL;
         end

         S_RDR: begin
            rd_addr  = right_idx[AW-1:0];
            state_in = S_RDL;
         end

         S_RDL: begin
            // right child data is back; test it against the sifted value
            pick_r_in = right_wins;
            big_in    = right_wins ? rd_data : sift_ff;
            rd_addr   = left_idx[AW-1:0];
            state_in  = S_DEC;
         end

         S_DEC: begin
            wr_en = 1'b1;
            if (left_wins || pick_r_ff) begin
               // pull the larger child up into the hole and descend
               wr_data  = left_wins ? rd_data : big_ff;
               node_in  = left_wins ? left_idx[AW-1:0] : right_idx[AW-1:0];
               state_in = S_RDR;
            end else begin
               // drop the sifted value into place
               wr_data  = sift_ff;
               state_in = extract_ff ? S_XNEXT : S_BNEXT;
            end
         end

         S_XNEXT: begin
            if (loop_ff <= CNT_W'(1)) begin
               k_in     = '0;
               state_in = S_ERD;
            end else begin
               size_in  = loop_ff - CNT_W'(1);
               loop_in  = loop_ff - CNT_W'(1);
               state_in = S_XRD0;
            end
         end

         S_XRD0: begin
            rd_addr  = '0;
            state_in = S_XRDE;
         end

         S_XRDE: begin
            hold_in  = rd_data;
            rd_addr  = AW'(size_ff);
            state_in = S_XSWP;
         end

         S_XSWP: begin
            // move old root to the end; sift the old end value from the root
            wr_en    = 1'b1;
            wr_addr  = AW'(size_ff);
            wr_data  = hold_ff;
            sift_in  = rd_data;
            node_in  = '0;
            state_in = S_RDR;
         end

         S_ERD: begin
            rd_addr  = k_ff;
            state_in = S_ELD;
         end

         S_ELD: begin
            rsp_valid_in = 1'b1;
            rsp_value_in = rd_data;
            rsp_final_in = (CNT_W'(k_ff) + CNT_W'(1)) == count_ff;
            rsp_ovf_in   = ovf_ff;
            state_in     = S_EWAIT;
         end

         S_EWAIT: begin
            // hold the result until taken, then fetch the next one
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               if (rsp_final_ff) begin
                  count_in = '0;
                  ovf_in   = 1'b0;
                  state_in = S_LOAD;
               end else begin
                  k_in     = k_ff + AW'(1);
                  rd_addr  = k_ff + AW'(1);
                  state_in = S_ELD;
               end
            end
         end

         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         extract_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         extract_ff   <= extract_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      loop_ff      <= loop_in;
      size_ff      <= size_in;
      node_ff      <= node_in;
      k_ff         <= k_in;
      sift_ff      <= sift_in;
      big_ff       <= big_in;
      pick_r_ff    <= pick_r_in;
      hold_ff      <= hold_in;
      rsp_value_ff <= rsp_value_in;
      rsp_final_ff <= rsp_final_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

endmodule

`default_nettype wire
